@@ rtl/markov_transition_table_top_macros.svh @@
// Assertion macros used by the checker file of the transition table.
`ifndef MARKOV_TRANSITION_TABLE_TOP_MACROS_SVH
`define MARKOV_TRANSITION_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("transition table check failed in the same cycle");

// Next-cycle implication, disabled while reset is asserted.
`define MTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("transition table check failed in the following cycle");

`endif

@@ rtl/mtt_pkg.sv @@
// Shared types and constants of the transition table.
package mtt_pkg;

  localparam int NODE_BITS  = 8;
  localparam int RAND_BITS  = 31;
  localparam int TOTAL_BITS = 20;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_SAT   = 2'd3
  } status_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

@@ rtl/markov_transition_table_top.sv @@
// Top level of the Markov transition table with weighted successor sampling.
// The input channel carries one request per beat: a record of an observed
// transition from from_node to to_node, or a sample of a successor of
// from_node driven by rand_value. Each request returns exactly one beat on
// the output channel with next_node, status and new_edge.
// Requests are handled one at a time. A record reads the source's node entry
// and then walks its successor list in the entry memory, one entry a cycle,
// until it finds to_node or reaches the end of the list. A sample first forms
// the bit-serial remainder of rand_value by the source total, then does the
// same walk over the cumulative counts. A sample of a source with a zero
// total skips both and answers with an empty status. The next request
// is accepted once the previous result has moved to the output register.
// After reset the node memory is cleared one node a cycle, while in_stall_o
// stays high. The output register lets the next request be accepted while a
// result still waits; if the receiver stalls, the result holds and a finished
// request waits until the register frees.
module markov_transition_table_top #(
  parameter int NODE_COUNT     = 256,
  parameter int MAX_SUCCESSORS = 16,
  parameter int COUNT_BITS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  from_node_i,
  input  logic [7:0]  to_node_i,
  input  logic [30:0] rand_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  next_node_o,
  output logic [1:0]  status_o,
  output logic        new_edge_o
);

  import mtt_pkg::*;

  localparam int SRC_W   = $clog2(NODE_COUNT);
  localparam int K_W     = (MAX_SUCCESSORS > 1) ? $clog2(MAX_SUCCESSORS) : 1;
  localparam int LEN_W   = $clog2(MAX_SUCCESSORS + 1);
  localparam int ENT_W   = NODE_BITS + COUNT_BITS;
  localparam int NODE_W  = LEN_W + TOTAL_BITS;
  localparam int ENT_DEP = NODE_COUNT << K_W;
  localparam int CUM_W   = ((COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS) + 1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_NODE  = 6'b000100,
    S_MOD   = 6'b001000,
    S_WALK  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  function automatic logic [SRC_W-1:0] reduce_src(input logic [NODE_BITS-1:0] node);
    logic [31:0] r;
    r = 32'(node);
    for (int k = NODE_BITS - 1; k >= 0; k--) begin
      if (r >= (32'(NODE_COUNT) << k)) begin
        r = r - (32'(NODE_COUNT) << k);
      end
    end
    return SRC_W'(r);
  endfunction

  state_e                 state_q, state_d;
  logic [SRC_W-1:0]       clr_q, clr_d;
  logic                   req_q, req_d;
  logic [SRC_W-1:0]       src_q, src_d;
  logic [NODE_BITS-1:0]   dst_q, dst_d;
  logic [RAND_BITS-1:0]   rnd_q, rnd_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [TOTAL_BITS-1:0]  total_q, total_d;
  logic [K_W-1:0]         k_q, k_d;
  logic [TOTAL_BITS-1:0]  r_q, r_d;
  logic [CUM_W-1:0]       cum_q, cum_d;
  logic [NODE_BITS-1:0]   res_next_q, res_next_d;
  status_e                res_status_q, res_status_d;
  logic                   res_new_q, res_new_d;
  logic                   out_valid_q, out_valid_d;
  logic [NODE_BITS-1:0]   out_next_q, out_next_d;
  status_e                out_status_q, out_status_d;
  logic                   out_new_q, out_new_d;

  logic                   in_accept;
  logic                   out_load;
  logic                   node_we;
  logic [SRC_W-1:0]       node_waddr;
  logic [NODE_W-1:0]      node_wdata;
  logic [SRC_W-1:0]       node_raddr;
  logic [NODE_W-1:0]      node_rdata;
  logic                   ent_we;
  logic [SRC_W+K_W-1:0]   ent_waddr;
  logic [ENT_W-1:0]       ent_wdata;
  logic [SRC_W+K_W-1:0]   ent_raddr;
  logic [ENT_W-1:0]       ent_rdata;
  logic [K_W-1:0]         k_inc;
  logic [LEN_W-1:0]       cur_len;
  logic [TOTAL_BITS-1:0]  cur_total;
  logic [COUNT_BITS-1:0]  ent_count;
  logic [NODE_BITS-1:0]   ent_id;
  logic [CUM_W-1:0]       cum_sum;
  logic                   walk_last;
  logic                   rec_go;
  logic                   rec_found;
  logic                   mod_start;
  mod_stat_t              mod_stat;
  logic [TOTAL_BITS-1:0]  mod_rem;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign out_load   = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  assign cur_len   = (state_q == S_NODE) ? node_rdata[TOTAL_BITS +: LEN_W] : len_q;
  assign cur_total = (state_q == S_NODE) ? node_rdata[TOTAL_BITS-1:0] : total_q;
  assign ent_count = ent_rdata[COUNT_BITS-1:0];
  assign ent_id    = ent_rdata[COUNT_BITS +: NODE_BITS];
  assign k_inc     = k_q + K_W'(1);
  assign cum_sum   = cum_q + CUM_W'(ent_count);
  assign walk_last = ((LEN_W'(k_q) + LEN_W'(1)) == len_q);

  assign node_raddr = (state_q == S_IDLE) ? reduce_src(from_node_i) : src_q;
  assign ent_raddr  = (state_q == S_WALK) ? {src_q, k_inc} : {src_q, {K_W{1'b0}}};

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    req_d        = req_q;
    src_d        = src_q;
    dst_d        = dst_q;
    rnd_d        = rnd_q;
    len_d        = len_q;
    total_d      = total_q;
    k_d          = k_q;
    r_d          = r_q;
    cum_d        = cum_q;
    res_next_d   = res_next_q;
    res_status_d = res_status_q;
    res_new_d    = res_new_q;
    node_we      = 1'b0;
    node_waddr   = src_q;
    node_wdata   = '0;
    ent_we       = 1'b0;
    ent_waddr    = {src_q, k_q};
    ent_wdata    = '0;
    rec_go       = 1'b0;
    rec_found    = 1'b0;
    mod_start    = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_q;
        clr_d      = clr_q + SRC_W'(1);
        if (clr_q == SRC_W'(NODE_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          req_d   = req_type_i;
          src_d   = reduce_src(from_node_i);
          dst_d   = to_node_i;
          rnd_d   = rand_value_i;
          state_d = S_NODE;
        end
      end
      S_NODE: begin
        len_d      = cur_len;
        total_d    = cur_total;
        k_d        = '0;
        cum_d      = '0;
        res_next_d = '0;
        res_new_d  = 1'b0;
        if (req_q) begin
          if (cur_total == '0) begin
            res_status_d = STAT_EMPTY;
            state_d      = S_RESP;
          end else begin
            mod_start = 1'b1;
            state_d   = S_MOD;
          end
        end else if (cur_len == '0) begin
          rec_go  = 1'b1;
          state_d = S_RESP;
        end else begin
          state_d = S_WALK;
        end
      end
      S_MOD: begin
        if (mod_stat.done) begin
          r_d     = mod_rem;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (req_q) begin
          cum_d = cum_sum;
          if (cum_sum > CUM_W'(r_q)) begin
            res_next_d   = ent_id;
            res_status_d = STAT_OK;
            state_d      = S_RESP;
          end else if (walk_last) begin
            res_status_d = STAT_EMPTY;
            state_d      = S_RESP;
          end else begin
            k_d = k_inc;
          end
        end else if (ent_id == dst_q) begin
          rec_go    = 1'b1;
          rec_found = 1'b1;
          state_d   = S_RESP;
        end else if (walk_last) begin
          rec_go  = 1'b1;
          state_d = S_RESP;
        end else begin
          k_d = k_inc;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (rec_go) begin
      res_next_d = '0;
      res_new_d  = 1'b0;
      if (rec_found) begin
        if ((ent_count == {COUNT_BITS{1'b1}}) || (cur_total == {TOTAL_BITS{1'b1}})) begin
          res_status_d = STAT_SAT;
        end else begin
          res_status_d = STAT_OK;
          ent_we       = 1'b1;
          ent_waddr    = {src_q, k_q};
          ent_wdata    = {dst_q, ent_count + COUNT_BITS'(1)};
          node_we      = 1'b1;
          node_waddr   = src_q;
          node_wdata   = {cur_len, cur_total + TOTAL_BITS'(1)};
        end
      end else if (cur_len >= LEN_W'(MAX_SUCCESSORS)) begin
        res_status_d = STAT_FULL;
      end else if (cur_total == {TOTAL_BITS{1'b1}}) begin
        res_status_d = STAT_SAT;
      end else begin
        res_status_d = STAT_OK;
        res_new_d    = 1'b1;
        ent_we       = 1'b1;
        ent_waddr    = {src_q, cur_len[K_W-1:0]};
        ent_wdata    = {dst_q, COUNT_BITS'(1)};
        node_we      = 1'b1;
        node_waddr   = src_q;
        node_wdata   = {cur_len + LEN_W'(1), cur_total + TOTAL_BITS'(1)};
      end
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_next_d   = out_next_q;
    out_status_d = out_status_q;
    out_new_d    = out_new_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_next_d   = res_next_q;
      out_status_d = res_status_q;
      out_new_d    = res_new_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    src_q        <= src_d;
    dst_q        <= dst_d;
    rnd_q        <= rnd_d;
    len_q        <= len_d;
    total_q      <= total_d;
    k_q          <= k_d;
    r_q          <= r_d;
    cum_q        <= cum_d;
    res_next_q   <= res_next_d;
    res_status_q <= res_status_d;
    res_new_q    <= res_new_d;
    out_next_q   <= out_next_d;
    out_status_q <= out_status_d;
    out_new_q    <= out_new_d;
  end

  mtt_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  mtt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENT_DEP)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  mtt_mod_unit u_mod_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (rnd_q),
    .divisor_i  (cur_total),
    .stat_o     (mod_stat),
    .rem_o      (mod_rem)
  );

  assign out_valid_o = out_valid_q;
  assign next_node_o = out_next_q;
  assign status_o    = out_status_q;
  assign new_edge_o  = out_new_q;

endmodule

@@ rtl/mtt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module mtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mtt_mod_unit.sv @@
// Bit-serial restoring remainder of the random value by the source total.
module mtt_mod_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [mtt_pkg::RAND_BITS-1:0]       dividend_i,
  input  logic [mtt_pkg::TOTAL_BITS-1:0]      divisor_i,
  output mtt_pkg::mod_stat_t                  stat_o,
  output logic [mtt_pkg::TOTAL_BITS-1:0]      rem_o
);

  import mtt_pkg::*;

  localparam int CNT_W = $clog2(RAND_BITS);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [RAND_BITS-1:0]  num_q, num_d;
  logic [TOTAL_BITS-1:0] div_q, div_d;
  logic [TOTAL_BITS-1:0] rem_q, rem_d;
  logic [TOTAL_BITS:0]   trial;
  logic [TOTAL_BITS:0]   diff;

  assign trial = {rem_q, num_q[RAND_BITS-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(RAND_BITS - 1);
      num_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[TOTAL_BITS-1:0];
      end else begin
        rem_d = trial[TOTAL_BITS-1:0];
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

@@ rtl/mtt_checker.sv @@
// Port-level checker of the transition table and its bind to the top level.
`include "markov_transition_table_top_macros.svh"

module mtt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  next_node_o,
  input logic [1:0]  status_o,
  input logic        new_edge_o
);

  import mtt_pkg::*;

  logic        out_wait;
  logic [10:0] out_payload;
  logic        out_ok;
  logic        node_chosen;
  logic        edge_added;

  assign out_wait    = out_valid_o && out_stall_i;
  assign out_payload = {next_node_o, status_o, new_edge_o};
  assign out_ok      = (status_o == STAT_OK);
  assign node_chosen = out_valid_o && (next_node_o != 8'd0);
  assign edge_added  = out_valid_o && new_edge_o;

  `MTT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_payload))
  `MTT_ASSERT_IMPL(a_node_ok, clk_i, rst_ni, node_chosen, out_ok)
  `MTT_ASSERT_IMPL(a_edge_ok, clk_i, rst_ni, edge_added, out_ok && (next_node_o == 8'd0))
  `MTT_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind markov_transition_table_top mtt_checker u_mtt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .next_node_o  (next_node_o),
  .status_o     (status_o),
  .new_edge_o   (new_edge_o)
);
